[hdl/stwa_pkg.sv]
// ----------------------------------------------------------------------------
// stwa_pkg
// Shared widths, codes and control types for the aging session table.
// ----------------------------------------------------------------------------
package stwa_pkg;

   localparam int SLOTS_DEFAULT = 8;

   localparam int MODE_W    = 3;
   localparam int KEY_W     = 64;
   localparam int LEVEL_W   = 2;
   localparam int TIME_W    = 32;
   localparam int TIMEOUT_W = 16;
   localparam int STATUS_W  = 2;
   localparam int INDEX_W   = 3;

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1800;

   localparam logic [MODE_W-1:0] MODE_CREATE = 3'd0;
   localparam logic [MODE_W-1:0] MODE_CHECK  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_QUERY  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_LOGOUT = 3'd3;
   localparam logic [MODE_W-1:0] MODE_SWEEP  = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_DENIED  = 2'd3;

   localparam logic [LEVEL_W-1:0] LEVEL_NONE = 2'd0;

   typedef struct packed {
      logic load;
      logic compare;
      logic commit;
   } ctrl_cmd_type;

endpackage

[hdl/stwa_ctrl.sv]
// ----------------------------------------------------------------------------
// stwa_ctrl
// Sequencer: load request, compare all slots, commit update and result.
// ----------------------------------------------------------------------------
module stwa_ctrl
   import stwa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   output ctrl_cmd_type cmd,
   output logic         rsp_valid
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CMP  = 3'b010,
      ST_CMT  = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_CMP;
         end
         ST_CMP:  state_in = ST_CMT;
         ST_CMT:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= cmd.commit;
      end
   end

   assign busy        = (state_ff != ST_IDLE);
   assign cmd.load    = (state_ff == ST_IDLE) && start;
   assign cmd.compare = (state_ff == ST_CMP);
   assign cmd.commit  = (state_ff == ST_CMT);
   assign rsp_valid   = rsp_valid_ff;

endmodule

[hdl/stwa_dp.sv]
// ----------------------------------------------------------------------------
// stwa_dp
// Slot storage, parallel key/age compare, priority select and write-back.
// ----------------------------------------------------------------------------
module stwa_dp
   import stwa_pkg::*;
#(
   parameter int SESSION_SLOTS = SLOTS_DEFAULT
)(
   input  logic                 clock,
   input  logic                 reset,
   input  ctrl_cmd_type         cmd,
   input  logic                 csr_write_enable,
   input  logic [TIMEOUT_W-1:0] csr_write_data,
   input  logic [MODE_W-1:0]    req_mode,
   input  logic [KEY_W-1:0]     req_key_upper,
   input  logic [KEY_W-1:0]     req_key_lower,
   input  logic [LEVEL_W-1:0]   req_privilege,
   input  logic [TIME_W-1:0]    req_now_seconds,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [LEVEL_W-1:0]   rsp_found_level,
   output logic [INDEX_W-1:0]   rsp_slot_index
);

   localparam int SLOT_W = (SESSION_SLOTS > 1) ? $clog2(SESSION_SLOTS) : 1;

   logic [MODE_W-1:0]    mode_ff;
   logic [KEY_W-1:0]     key_upper_ff;
   logic [KEY_W-1:0]     key_lower_ff;
   logic [LEVEL_W-1:0]   priv_ff;
   logic [TIME_W-1:0]    now_ff;
   logic [TIMEOUT_W-1:0] timeout_ff;

   logic [SESSION_SLOTS-1:0] valid_ff;
   logic [SESSION_SLOTS-1:0] valid_in;
   logic [KEY_W-1:0]         slot_upper_ff [SESSION_SLOTS];
   logic [KEY_W-1:0]         slot_lower_ff [SESSION_SLOTS];
   logic [LEVEL_W-1:0]       slot_level_ff [SESSION_SLOTS];
   logic [TIME_W-1:0]        slot_time_ff  [SESSION_SLOTS];

   logic [SESSION_SLOTS-1:0] match_ff;
   logic [SESSION_SLOTS-1:0] stale_ff;
   logic [SESSION_SLOTS-1:0] match_in;
   logic [SESSION_SLOTS-1:0] stale_in;

   logic [SESSION_SLOTS-1:0] live;
   logic [SESSION_SLOTS-1:0] hit_vec;
   logic                     free_found;
   logic [SLOT_W-1:0]        free_idx;
   logic                     hit_found;
   logic [SLOT_W-1:0]        hit_idx;

   logic              wr_new;
   logic              wr_time;
   logic [SLOT_W-1:0] wr_idx;

   logic [STATUS_W-1:0] status_ff, status_in;
   logic [LEVEL_W-1:0]  level_ff, level_in;
   logic [INDEX_W-1:0]  index_ff, index_in;

   // request word and timeout
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff      <= req_mode;
         key_upper_ff <= req_key_upper;
         key_lower_ff <= req_key_lower;
         priv_ff      <= req_privilege;
         now_ff       <= req_now_seconds;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_write_enable) begin
         timeout_ff <= csr_write_data;
      end
   end

   // per-slot key match and age test
   always_comb begin
      for (int i = 0; i < SESSION_SLOTS; i++) begin
         match_in[i] = (slot_upper_ff[i] == key_upper_ff) &&
                       (slot_lower_ff[i] == key_lower_ff);
         stale_in[i] = (now_ff - slot_time_ff[i]) > TIME_W'(timeout_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.compare) begin
         match_ff <= match_in;
         stale_ff <= stale_in;
      end
   end

   // priority select, lowest slot wins
   assign live    = valid_ff & ~stale_ff;
   assign hit_vec = ((mode_ff == MODE_CHECK) ? live : valid_ff) & match_ff;

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      hit_found  = 1'b0;
      hit_idx    = '0;
      for (int i = SESSION_SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SLOT_W'(i);
         end
         if (hit_vec[i]) begin
            hit_found = 1'b1;
            hit_idx   = SLOT_W'(i);
         end
      end
   end

   always_comb begin
      valid_in  = valid_ff;
      wr_new    = 1'b0;
      wr_time   = 1'b0;
      wr_idx    = hit_idx;
      status_in = STATUS_OK;
      level_in  = LEVEL_NONE;
      index_in  = '0;
      case (mode_ff)
         MODE_CREATE: begin
            wr_idx = free_idx;
            if (free_found) begin
               valid_in[free_idx] = 1'b1;
               wr_new             = 1'b1;
               wr_time            = 1'b1;
               level_in           = priv_ff;
               index_in           = INDEX_W'(free_idx);
            end else begin
               status_in = STATUS_FULL;
            end
         end
         MODE_CHECK: begin
            if (priv_ff != LEVEL_NONE) begin
               valid_in = live;
               if (hit_found) begin
                  wr_time  = 1'b1;
                  level_in = slot_level_ff[hit_idx];
                  index_in = INDEX_W'(hit_idx);
                  if (slot_level_ff[hit_idx] < priv_ff) status_in = STATUS_DENIED;
               end else begin
                  status_in = STATUS_MISSING;
               end
            end
         end
         MODE_QUERY, MODE_LOGOUT: begin
            if (hit_found && !stale_ff[hit_idx]) begin
               wr_time  = 1'b1;
               level_in = slot_level_ff[hit_idx];
               index_in = INDEX_W'(hit_idx);
               if (mode_ff == MODE_LOGOUT) valid_in[hit_idx] = 1'b0;
            end else begin
               status_in = STATUS_MISSING;
               if (hit_found) valid_in[hit_idx] = 1'b0;
            end
         end
         MODE_SWEEP: begin
            valid_in = live;
         end
         default: begin
         end
      endcase
   end

   // write-back
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.commit) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         if (wr_new) begin
            slot_upper_ff[wr_idx] <= key_upper_ff;
            slot_lower_ff[wr_idx] <= key_lower_ff;
            slot_level_ff[wr_idx] <= priv_ff;
         end
         if (wr_time) slot_time_ff[wr_idx] <= now_ff;
         status_ff <= status_in;
         level_ff  <= level_in;
         index_ff  <= index_in;
      end
   end

   assign rsp_status      = status_ff;
   assign rsp_found_level = level_ff;
   assign rsp_slot_index  = index_ff;

endmodule

[hdl/session_table_with_aging_core.sv]
// ----------------------------------------------------------------------------
// session_table_with_aging_core
// Session table with idle-timeout aging; create, check, query, logout, sweep.
//
//   channel  ports                                   handshake
//   request  req_mode, req_key_*, req_privilege,     start & !busy
//            req_now_seconds
//   response rsp_status, rsp_found_level,            rsp_valid, one cycle
//            rsp_slot_index
//   csr      csr_write_data (idle timeout)           csr_write_enable
//
// Each word: load, parallel compare of all slots, commit; none taken while busy.
// rsp_valid is registered from the commit state; busy is high in compare and commit.
// Sync reset clears all slot valid bits and sets the timeout to 1800 s.
// The response side cannot stall; each result shows for a single cycle.
// ----------------------------------------------------------------------------
module session_table_with_aging_core
   import stwa_pkg::*;
#(
   parameter int SESSION_SLOTS = SLOTS_DEFAULT
)(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [MODE_W-1:0]    req_mode,
   input  logic [KEY_W-1:0]     req_key_upper,
   input  logic [KEY_W-1:0]     req_key_lower,
   input  logic [LEVEL_W-1:0]   req_privilege,
   input  logic [TIME_W-1:0]    req_now_seconds,
   output logic                 rsp_valid,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [LEVEL_W-1:0]   rsp_found_level,
   output logic [INDEX_W-1:0]   rsp_slot_index,
   input  logic                 csr_write_enable,
   input  logic [TIMEOUT_W-1:0] csr_write_data
);

   ctrl_cmd_type cmd;

   stwa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .cmd       (cmd),
      .rsp_valid (rsp_valid)
   );

   stwa_dp #(
      .SESSION_SLOTS (SESSION_SLOTS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_mode         (req_mode),
      .req_key_upper    (req_key_upper),
      .req_key_lower    (req_key_lower),
      .req_privilege    (req_privilege),
      .req_now_seconds  (req_now_seconds),
      .rsp_status       (rsp_status),
      .rsp_found_level  (rsp_found_level),
      .rsp_slot_index   (rsp_slot_index)
   );

endmodule

[hdl/stwa_checker.sv]
// ----------------------------------------------------------------------------
// stwa_checker
// Port-level checks on request/response timing and result encoding.
// ----------------------------------------------------------------------------
module stwa_checker
   import stwa_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic                rsp_valid,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [LEVEL_W-1:0]  rsp_found_level,
   input logic [INDEX_W-1:0]  rsp_slot_index
);

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after accept");

   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> ##2 rsp_valid)
      else $error("response missing three cycles after accept");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   a_idle_on_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("busy while response shown");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_FULL || rsp_status == STATUS_MISSING)
      |-> rsp_found_level == LEVEL_NONE && rsp_slot_index == '0)
      else $error("failed word carries level or slot");

endmodule

bind session_table_with_aging_core stwa_checker u_checker (.*);
